// ===== sv/tcw_pkg.sv =====
package tcw_pkg;

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATTR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_ATTR   = 1'b1;

  localparam logic [7:0] RESET_DEFAULT_ATTR = 8'd15;
  localparam logic [7:0] RESET_ERROR_ATTR   = 8'd4;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] DASH_CODE    = 8'h2D;
  localparam logic [7:0] ERROR_CODE   = 8'h45;
  localparam logic [7:0] SPACE_CODE   = 8'h20;

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic       mode;
    logic       use_cursor;
    logic [7:0] column;
    logic [7:0] row_index;
    logic [7:0] character;
    logic [7:0] attribute;
  } tcw_req_t;

  typedef struct packed {
    logic [7:0] cell_character;
    logic [7:0] cell_attribute;
    logic [6:0] cursor_column;
    logic [4:0] cursor_row;
    logic       out_of_range;
  } tcw_rsp_t;

endpackage

// ===== sv/tcw_cell_ram.sv =====
module tcw_cell_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tcw_addr_unit.sv =====
module tcw_addr_unit #(
  parameter int unsigned COLS = 80,
  parameter int unsigned CW   = 7,
  parameter int unsigned RW   = 5,
  parameter int unsigned AW   = 11
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [CW-1:0] col_i,
  input  logic [RW-1:0] row_i,
  output logic [AW-1:0] addr_o
);

  logic [AW-1:0] addr_q;
  logic [AW-1:0] addr_d;

  assign addr_d = AW'(32'(row_i) * 32'(COLS) + 32'(col_i));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      addr_q <= addr_d;
    end
  end

  assign addr_o = addr_q;

endmodule

// ===== sv/tcw_seq.sv =====
module tcw_seq #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25,
  parameter int unsigned CW   = 7,
  parameter int unsigned RW   = 5,
  parameter int unsigned AW   = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcw_pkg::tcw_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tcw_pkg::tcw_rsp_t out_rsp_o,
  input  logic [7:0]        dflt_attr_i,
  input  logic [7:0]        err_attr_i,
  output logic              addr_en_o,
  output logic [CW-1:0]     addr_col_o,
  output logic [RW-1:0]     addr_row_o,
  input  logic [AW-1:0]     addr_i,
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output logic [15:0]       ram_wdata_o,
  output logic              ram_re_o,
  output logic [AW-1:0]     ram_raddr_o,
  input  logic [15:0]       ram_rdata_i
);
  import tcw_pkg::*;

  localparam int unsigned CELLS = COLS * ROWS;
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] FIRST_ROW1 = AW'(COLS);
  localparam logic [AW-1:0] BOTTOM_ROW = AW'(CELLS - COLS);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ADDR  = 9'b000000010,
    S_READ  = 9'b000000100,
    S_WRITE = 9'b000001000,
    S_SC_RD = 9'b000010000,
    S_SC_WR = 9'b000100000,
    S_FILL  = 9'b001000000,
    S_CLEAR = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_e;

  state_e        state_q, state_d;
  logic          init_q, init_d;
  logic          is_read_q, is_read_d;
  logic          rd_ok_q, rd_ok_d;
  logic          oor_q, oor_d;
  logic [7:0]    ch_q, ch_d;
  logic [7:0]    attr_q, attr_d;
  logic [CW-1:0] pcol_q, pcol_d;
  logic [RW-1:0] prow_q, prow_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  tcw_rsp_t      out_q, out_d;

  logic          on_screen;
  logic          newline;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          wrap;
  logic          scroll;
  logic [7:0]    clr_attr;

  assign on_screen = ({1'b0, in_req_i.column} < 9'(COLS)) &&
                     ({1'b0, in_req_i.row_index} < 9'(ROWS));
  assign newline   = (ch_q == NEWLINE_CODE);
  assign col_inc   = {1'b0, pcol_q} + (CW+1)'(1);
  assign row_inc   = {1'b0, prow_q} + (RW+1)'(1);
  assign wrap      = newline || (col_inc == (CW+1)'(COLS));
  assign scroll    = wrap && (row_inc == (RW+1)'(ROWS));
  assign clr_attr  = init_q ? RESET_DEFAULT_ATTR : dflt_attr_i;

  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    is_read_d   = is_read_q;
    rd_ok_d     = rd_ok_q;
    oor_d       = oor_q;
    ch_d        = ch_q;
    attr_d      = attr_q;
    pcol_d      = pcol_q;
    prow_d      = prow_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    addr_en_o   = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q;
    ram_wdata_o = {clr_attr, SPACE_CODE};
    ram_re_o    = 1'b0;
    ram_raddr_o = cnt_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ch_d      = in_req_i.character;
          attr_d    = (in_req_i.attribute == 8'd0) ? dflt_attr_i : in_req_i.attribute;
          is_read_d = (in_req_i.mode == MODE_READ);
          rd_ok_d   = (in_req_i.mode == MODE_READ) && on_screen;
          oor_d     = 1'b0;
          pcol_d    = CW'(in_req_i.column);
          prow_d    = RW'(in_req_i.row_index);
          if (in_req_i.mode == MODE_READ) begin
            state_d = on_screen ? S_ADDR : S_FIN;
          end else if (in_req_i.use_cursor) begin
            pcol_d  = cur_col_q;
            prow_d  = cur_row_q;
            state_d = S_ADDR;
          end else if (on_screen) begin
            state_d = S_ADDR;
          end else begin
            oor_d   = 1'b1;
            ch_d    = ERROR_CODE;
            attr_d  = (err_attr_i == 8'd0) ? dflt_attr_i : err_attr_i;
            cnt_d   = '0;
            state_d = S_CLEAR;
          end
        end
      end
      S_ADDR: begin
        addr_en_o = 1'b1;
        state_d   = is_read_q ? S_READ : S_WRITE;
      end
      S_READ: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = addr_i;
        state_d     = S_FIN;
      end
      S_WRITE: begin
        ram_we_o    = !newline;
        ram_waddr_o = addr_i;
        ram_wdata_o = {attr_q, ch_q};
        if (scroll) begin
          cur_col_d = '0;
          cur_row_d = RW'(ROWS - 1);
          cnt_d     = FIRST_ROW1;
          state_d   = S_SC_RD;
        end else begin
          cur_col_d = wrap ? '0 : col_inc[CW-1:0];
          cur_row_d = wrap ? row_inc[RW-1:0] : prow_q;
          state_d   = S_FIN;
        end
      end
      S_SC_RD: begin
        ram_re_o = 1'b1;
        state_d  = S_SC_WR;
      end
      S_SC_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cnt_q - FIRST_ROW1;
        ram_wdata_o = ram_rdata_i;
        if (cnt_q == LAST_CELL) begin
          cnt_d   = BOTTOM_ROW;
          state_d = S_FILL;
        end else begin
          cnt_d   = cnt_q + AW'(1);
          state_d = S_SC_RD;
        end
      end
      S_FILL: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = {DASH_CODE, DASH_CODE};
        if (cnt_q == LAST_CELL) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      S_CLEAR: begin
        ram_we_o = 1'b1;
        if (cnt_q == LAST_CELL) begin
          if (init_q) begin
            init_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            pcol_d  = '0;
            prow_d  = '0;
            state_d = S_ADDR;
          end
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.cell_character = rd_ok_q ? ram_rdata_i[7:0] : 8'd0;
          out_d.cell_attribute = rd_ok_q ? ram_rdata_i[15:8] : 8'd0;
          out_d.cursor_column  = 7'(cur_col_q);
          out_d.cursor_row     = 5'(cur_row_q);
          out_d.out_of_range   = oor_q;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      init_q      <= 1'b1;
      cnt_q       <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      cnt_q       <= cnt_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_read_q <= is_read_d;
    rd_ok_q   <= rd_ok_d;
    oor_q     <= oor_d;
    ch_q      <= ch_d;
    attr_q    <= attr_d;
    pcol_q    <= pcol_d;
    prow_q    <= prow_d;
    out_q     <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign addr_col_o  = pcol_q;
  assign addr_row_o  = prow_q;

endmodule

// ===== sv/text_console_writer_core.sv =====
// Text-mode console writer with a cursor and a store of character cells.
//
// Requests arrive on in_valid_i/in_ready_o with payload in_req_i; each request
// yields exactly one response on out_valid_o/out_ready_i with payload out_rsp_o.
// A put request writes one character, or takes a newline, at a given cell or at the
// cursor, and a read request returns one cell; both report the cursor after the request.
// The default and error attribute registers are written through cfg_we_i,
// cfg_index_i and cfg_wdata_i; write only while the block is idle (unchecked).
//
// A plain put or an on-screen read steps through the sequencer's address multiply,
// cell store access and response load before the next request is accepted. A read
// off the screen skips the store. A put that passes the last cell scrolls the screen
// through the single port pair of the cell store. A put off the screen clears every
// cell, one per cycle. After reset the block clears the store to spaces with
// attribute 15, and in_ready_o stays low while it does so; configuration writes
// are taken meanwhile. A finished response waits in an output register while the
// receiver stalls, and the next request is accepted meanwhile; its response waits
// for that slot.
module text_console_writer_core #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tcw_pkg::tcw_req_t              in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tcw_pkg::tcw_rsp_t              out_rsp_o,
  input  logic                           cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [7:0]                     cfg_wdata_i
);
  import tcw_pkg::*;

  localparam int unsigned CELLS = COLS * ROWS;
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned AW    = $clog2(CELLS);

  logic [7:0]    dflt_attr_q, dflt_attr_d;
  logic [7:0]    err_attr_q, err_attr_d;

  logic          addr_en;
  logic [CW-1:0] addr_col;
  logic [RW-1:0] addr_row;
  logic [AW-1:0] addr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  always_comb begin
    dflt_attr_d = dflt_attr_q;
    err_attr_d  = err_attr_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DEFAULT_ATTR: dflt_attr_d = cfg_wdata_i;
        REG_ERROR_ATTR:   err_attr_d  = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_attr_q <= RESET_DEFAULT_ATTR;
      err_attr_q  <= RESET_ERROR_ATTR;
    end else begin
      dflt_attr_q <= dflt_attr_d;
      err_attr_q  <= err_attr_d;
    end
  end

  tcw_seq #(
    .COLS (COLS),
    .ROWS (ROWS),
    .CW   (CW),
    .RW   (RW),
    .AW   (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .dflt_attr_i (dflt_attr_q),
    .err_attr_i  (err_attr_q),
    .addr_en_o   (addr_en),
    .addr_col_o  (addr_col),
    .addr_row_o  (addr_row),
    .addr_i      (addr),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  tcw_addr_unit #(
    .COLS (COLS),
    .CW   (CW),
    .RW   (RW),
    .AW   (AW)
  ) u_addr_unit (
    .clk_i  (clk_i),
    .en_i   (addr_en),
    .col_i  (addr_col),
    .row_i  (addr_row),
    .addr_o (addr)
  );

  tcw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import tcw_pkg::*;

  localparam int unsigned COLS = 80;
  localparam int unsigned ROWS = 25;
  localparam int unsigned CELLS = COLS * ROWS;
  localparam int unsigned PHASES = 6;
  localparam int unsigned RANDOM_PER_PHASE = 205;
  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  localparam int unsigned IDLE_PERCENT = 28;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  tcw_req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  tcw_rsp_t out_rsp_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [7:0] cfg_wdata_i = '0;

  logic [15:0] screen_model [CELLS];
  int unsigned cursor_model;
  logic [7:0] dflt_attr;
  logic [7:0] err_attr;

  tcw_req_t pending_reqs[$];
  tcw_rsp_t expected_rsps[$];
  tcw_rsp_t want_rsp;
  int unsigned queued_count = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit req_taken = 1'b0;
  bit steady_flow = 1'b0;

  text_console_writer_core #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen_model[i] = {dflt_attr, SPACE_CODE};
  endfunction

  // Writes one character or takes a newline at pos, scrolling when the
  // cursor runs past the last cell. Returns the new cursor position.
  function automatic int unsigned place_char(int unsigned pos, logic [7:0] ch, logic [7:0] at);
    int unsigned nxt;
    if (at == 8'd0) at = dflt_attr;
    if (ch == NEWLINE_CODE) begin
      nxt = (pos / COLS + 1) * COLS;
    end else begin
      if (pos < CELLS) screen_model[pos] = {at, ch};
      nxt = pos + 1;
    end
    if (nxt >= CELLS) begin
      for (int i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen_model[i] = {DASH_CODE, DASH_CODE};
      nxt = nxt - COLS;
      if (nxt >= CELLS) nxt = CELLS - COLS;
    end
    return nxt;
  endfunction

  function automatic tcw_rsp_t console_response(tcw_req_t r);
    tcw_rsp_t rsp;
    int unsigned col;
    int unsigned row;
    logic on_screen;
    rsp = '0;
    col = int'(r.column);
    row = int'(r.row_index);
    on_screen = (col < COLS) && (row < ROWS);
    if (r.mode == MODE_READ) begin
      if (on_screen) {rsp.cell_attribute, rsp.cell_character} = screen_model[row * COLS + col];
    end else if (r.use_cursor) begin
      cursor_model = place_char(cursor_model % CELLS, r.character, r.attribute);
    end else if (on_screen) begin
      cursor_model = place_char(row * COLS + col, r.character, r.attribute);
    end else begin
      blank_screen();
      cursor_model = place_char(0, ERROR_CODE, err_attr);
      rsp.out_of_range = 1'b1;
    end
    rsp.cursor_column = 7'(cursor_model % COLS);
    rsp.cursor_row = 5'(cursor_model / COLS);
    return rsp;
  endfunction

  task automatic check_field(input string label, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: response with none expected, actual %p", $time, out_rsp_o);
          error_count++;
        end else begin
          want_rsp = expected_rsps.pop_front();
          check_field("cell_character", want_rsp.cell_character, out_rsp_o.cell_character);
          check_field("cell_attribute", want_rsp.cell_attribute, out_rsp_o.cell_attribute);
          check_field("cursor_column", want_rsp.cursor_column, out_rsp_o.cursor_column);
          check_field("cursor_row", want_rsp.cursor_row, out_rsp_o.cursor_row);
          check_field("out_of_range", want_rsp.out_of_range, out_rsp_o.out_of_range);
        end
      end
      req_taken = in_valid_i && in_ready_o;
      if (req_taken) expected_rsps.push_back(console_response(in_req_i));
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        if (pending_reqs.size() != 0 &&
            (steady_flow || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          in_req_i <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  task automatic queue_req(input logic mode, input logic use_cursor, input int unsigned col,
                           input int unsigned row, input int unsigned ch,
                           input int unsigned at);
    tcw_req_t r;
    r.mode = mode;
    r.use_cursor = use_cursor;
    r.column = 8'(col);
    r.row_index = 8'(row);
    r.character = 8'(ch);
    r.attribute = 8'(at);
    pending_reqs.push_back(r);
    queued_count++;
  endtask

  function automatic int unsigned rand_char();
    if ($urandom_range(0, 9) == 0) return NEWLINE_CODE;
    return $urandom_range(0, 255);
  endfunction

  function automatic int unsigned rand_attr();
    if ($urandom_range(0, 9) < 3) return 0;
    return $urandom_range(0, 255);
  endfunction

  // The largest share of bursts types a run of text from a placed start, often on
  // the bottom row so that the run scrolls; the rest are reads, single puts,
  // off-screen puts and requests with every field random.
  task automatic queue_random_burst();
    int unsigned pick;
    int unsigned col;
    int unsigned row;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 3) == 0) begin
        row = ROWS - 1;
        col = $urandom_range(COLS - 10, COLS - 1);
      end else begin
        row = $urandom_range(0, ROWS - 1);
        col = $urandom_range(0, COLS - 1);
      end
      queue_req(MODE_PUT, 1'b0, col, row, rand_char(), rand_attr());
      repeat ($urandom_range(3, 12)) begin
        queue_req(MODE_PUT, 1'b1, $urandom_range(0, 255), $urandom_range(0, 255),
                  rand_char(), rand_attr());
      end
    end else if (pick < 75) begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_req(MODE_READ, 1'($urandom_range(0, 1)), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        end else begin
          queue_req(MODE_READ, 1'($urandom_range(0, 1)), $urandom_range(0, COLS - 1),
                    $urandom_range(0, ROWS - 1), $urandom_range(0, 255),
                    $urandom_range(0, 255));
        end
      end
    end else if (pick < 90) begin
      queue_req(MODE_PUT, 1'b0, $urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1),
                rand_char(), rand_attr());
    end else if (pick < 94) begin
      if ($urandom_range(0, 1) == 0) begin
        queue_req(MODE_PUT, 1'b0, $urandom_range(COLS, 255), $urandom_range(0, 255),
                  rand_char(), rand_attr());
      end else begin
        queue_req(MODE_PUT, 1'b0, $urandom_range(0, 255), $urandom_range(ROWS, 255),
                  rand_char(), rand_attr());
      end
    end else begin
      queue_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_rsps.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_DEFAULT_ATTR) begin
      dflt_attr = value;
    end else begin
      err_attr = value;
    end
  endtask

  initial begin
    int unsigned target;
    dflt_attr = RESET_DEFAULT_ATTR;
    err_attr = RESET_ERROR_ATTR;
    blank_screen();
    cursor_model = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        repeat (8) @(posedge clk_i);
        case (p)
          1: begin
            write_register(REG_DEFAULT_ATTR, 8'h00);
            write_register(REG_ERROR_ATTR, 8'hFF);
          end
          2: begin
            write_register(REG_DEFAULT_ATTR, 8'hFF);
            write_register(REG_ERROR_ATTR, 8'h00);
          end
          default: begin
            write_register(REG_DEFAULT_ATTR, 8'($urandom_range(0, 255)));
            write_register(REG_ERROR_ATTR, 8'($urandom_range(0, 255)));
          end
        endcase
      end
      steady_flow = (p == 2);
      case (p)
        0: begin
          queue_req(MODE_READ, 1'b0, 0, 0, 0, 0);
          queue_req(MODE_READ, 1'b0, COLS - 1, ROWS - 1, 8'hFF, 8'hFF);
          queue_req(MODE_READ, 1'b0, COLS, 0, 0, 0);
          queue_req(MODE_READ, 1'b1, 255, 255, 0, 0);
          queue_req(MODE_PUT, 1'b0, 0, 0, 8'h41, 0);
          queue_req(MODE_PUT, 1'b1, 0, 0, 8'hFF, 8'hFF);
          queue_req(MODE_PUT, 1'b0, COLS - 1, ROWS - 1, 8'h23, 8'h01);
          queue_req(MODE_READ, 1'b0, COLS - 1, ROWS - 2, 0, 0);
          queue_req(MODE_READ, 1'b0, 0, ROWS - 1, 0, 0);
          queue_req(MODE_PUT, 1'b1, 0, 0, NEWLINE_CODE, 0);
          queue_req(MODE_PUT, 1'b0, 5, 3, NEWLINE_CODE, 8'h33);
          queue_req(MODE_READ, 1'b0, 5, 3, 0, 0);
          queue_req(MODE_PUT, 1'b0, COLS - 1, 0, 8'h7A, 8'h80);
          queue_req(MODE_PUT, 1'b0, COLS, 0, 8'h41, 8'h12);
          queue_req(MODE_READ, 1'b0, 0, 0, 0, 0);
          queue_req(MODE_READ, 1'b0, 1, 0, 0, 0);
          queue_req(MODE_PUT, 1'b0, 0, ROWS, 8'h42, 0);
          queue_req(MODE_PUT, 1'b0, 255, 255, 8'h43, 8'hFF);
          queue_req(MODE_PUT, 1'b1, 255, 255, 8'h00, 8'h7F);
        end
        1: begin
          queue_req(MODE_PUT, 1'b0, 10, 10, 8'h55, 0);
          queue_req(MODE_READ, 1'b0, 10, 10, 0, 0);
          queue_req(MODE_PUT, 1'b0, 100, 3, 8'h20, 8'h20);
          queue_req(MODE_READ, 1'b0, 0, 0, 0, 0);
          queue_req(MODE_READ, 1'b0, 2, 2, 0, 0);
        end
        2: begin
          queue_req(MODE_PUT, 1'b0, 0, 30, 8'h58, 8'h01);
          queue_req(MODE_READ, 1'b0, 0, 0, 0, 0);
        end
        default: ;
      endcase
      target = queued_count + RANDOM_PER_PHASE;
      while (queued_count < target) queue_random_burst();
    end
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tcw_pkg.sv
sv/tcw_cell_ram.sv
sv/tcw_addr_unit.sv
sv/tcw_seq.sv
sv/text_console_writer_core.sv
bench/tb_top.sv
